>>> rtl/rf46r_pkg.sv
// shared types, constants and the 4b6b symbol decoder of the frame receiver
package rf46r_pkg;

  localparam int unsigned PeriodW = 12;
  localparam int unsigned TagW    = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned NumW    = LenW + 1;
  localparam int unsigned PosW    = 10;
  localparam int unsigned BtnW    = 3;
  localparam int unsigned PcW     = 3;

  localparam logic [PeriodW-1:0] PeriodReset = 12'd500;
  localparam logic [TagW-1:0]    TagReset    = 8'd126;
  localparam logic [PosW-1:0]    HeldXReset  = 10'd504;
  localparam logic [PosW-1:0]    HeldYReset  = 10'd520;
  localparam logic [11:0]        SyncWord    = 12'hb38;
  localparam logic [3:0]         BitsPerByte = 4'd12;
  localparam logic [3:0]         RunMax      = 4'd15;
  localparam logic [7:0]         LenMin      = 8'd4;
  localparam logic [7:0]         LenMax      = 8'd15;
  localparam logic [4:0]         MinGoodLen  = 5'd5;

  // configuration register indexes
  localparam logic CfgPeriod = 1'b0;
  localparam logic CfgTag    = 1'b1;

  // microprogram step addresses
  localparam logic [PcW-1:0] StepWait  = 3'd0;
  localparam logic [PcW-1:0] StepDiv   = 3'd1;
  localparam logic [PcW-1:0] StepCheck = 3'd2;
  localparam logic [PcW-1:0] StepShift = 3'd3;
  localparam logic [PcW-1:0] StepPut   = 3'd4;

  typedef struct packed {
    logic            run_level;
    logic [LenW-1:0] run_length_us;
  } in_item_t;

  typedef struct packed {
    logic            new_data;
    logic [PosW-1:0] x_position;
    logic [PosW-1:0] y_position;
    logic [BtnW-1:0] buttons;
  } out_item_t;

  typedef enum logic [2:0] {
    CondFire    = 3'd0,
    CondDivDone = 3'd1,
    CondRunBad  = 3'd2,
    CondLast    = 3'd3,
    CondOutFree = 3'd4
  } cond_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic div;
    logic shift;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    logic div_done;
    logic run_bad;
    logic last;
    logic out_free;
  } status_t;

  typedef struct packed {
    ctrl_t          ctrl;
    cond_e          cond;
    logic           stay;
    logic [PcW-1:0] target;
  } ucode_t;

  // returns {invalid, nibble}
  function automatic logic [4:0] sym_decode(logic [5:0] code);
    case (code)
      6'h0d:   return 5'h00;
      6'h0e:   return 5'h01;
      6'h13:   return 5'h02;
      6'h15:   return 5'h03;
      6'h16:   return 5'h04;
      6'h19:   return 5'h05;
      6'h1a:   return 5'h06;
      6'h1c:   return 5'h07;
      6'h23:   return 5'h08;
      6'h25:   return 5'h09;
      6'h26:   return 5'h0a;
      6'h29:   return 5'h0b;
      6'h2a:   return 5'h0c;
      6'h2c:   return 5'h0d;
      6'h32:   return 5'h0e;
      6'h34:   return 5'h0f;
      default: return 5'h10;
    endcase
  endfunction

endpackage

>>> rtl/rf_4b6b_frame_receiver_unit.sv
// top level of the 4b6b radio frame receiver
// a run of b bits (1 to 14) is taken in the wait step, divided, checked, shifted in and then put
// a run that rounds to q = 0 or to 15 and more bits (count stops at 15) skips the shift step
// one request at a time: the next is taken only after the put step has placed the result
// subtract loop and one-bit-a-cycle shifter set the rate; the put step waits for a free slot
// reset (rst_ni, asynchronous, active low) returns period 500, tag 126, x 504, y 520, no sync
module rf_4b6b_frame_receiver_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rf46r_pkg::in_item_t           in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rf46r_pkg::out_item_t          out_item_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rf46r_pkg::PeriodW-1:0] cfg_wdata_i
);
  import rf46r_pkg::*;

  // configuration registers
  logic [PeriodW-1:0] period_q;
  logic [TagW-1:0]    tag_q;

  // sequencer control and status
  ctrl_t   ctrl;
  status_t status;

  logic            div_done, run_bad, last, fresh;
  logic [PosW-1:0] held_x, held_y;
  logic [BtnW-1:0] held_btn;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      tag_q    <= TagReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPeriod: period_q <= cfg_wdata_i;
        CfgTag:    tag_q    <= cfg_wdata_i[TagW-1:0];
        default:   ;
      endcase
    end
  end

  assign in_ready_o = ctrl.in_ready;

  // request taken only in the wait step; result slot free when empty or being drained
  assign status.fire     = in_valid_i & ctrl.in_ready;
  assign status.div_done = div_done;
  assign status.run_bad  = run_bad;
  assign status.last     = last;
  assign status.out_free = !out_valid_q || out_ready_i;

  rf46r_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // load is meaningful only with the handshake
  ctrl_t dp_ctrl;
  always_comb begin
    dp_ctrl      = ctrl;
    dp_ctrl.load = ctrl.load & in_valid_i;
  end

  rf46r_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dp_ctrl),
    .item_i     (in_item_i),
    .period_i   (period_q),
    .tag_i      (tag_q),
    .div_done_o (div_done),
    .run_bad_o  (run_bad),
    .last_o     (last),
    .fresh_o    (fresh),
    .held_x_o   (held_x),
    .held_y_o   (held_y),
    .held_btn_o (held_btn)
  );

  // result capture: the put step waits until the slot is free
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.emit && status.out_free) begin
      out_valid_d           = 1'b1;
      out_item_d.new_data   = fresh;
      out_item_d.x_position = held_x;
      out_item_d.y_position = held_y;
      out_item_d.buttons    = held_btn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in work");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && out_item_q == $past(out_item_q))
    else $error("pending result overwritten");
`endif

endmodule

>>> rtl/rf46r_sequencer.sv
// microprogram rom and step counter
module rf46r_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rf46r_pkg::status_t status_i,
  output rf46r_pkg::ctrl_t   ctrl_o
);
  import rf46r_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         uc;
  logic           cond_hit;

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    w = '{ctrl: '0, cond: CondFire, stay: 1'b1, target: StepWait};
    case (pc)
      StepWait:  begin
        w.ctrl.in_ready = 1'b1;
        w.ctrl.load     = 1'b1;
        w.cond          = CondFire;
        w.target        = StepDiv;
      end
      StepDiv:   begin
        w.ctrl.div = 1'b1;
        w.cond     = CondDivDone;
        w.target   = StepCheck;
      end
      StepCheck: begin
        w.cond   = CondRunBad;
        w.stay   = 1'b0;
        w.target = StepPut;
      end
      StepShift: begin
        w.ctrl.shift = 1'b1;
        w.cond       = CondLast;
        w.target     = StepPut;
      end
      StepPut:   begin
        w.ctrl.emit = 1'b1;
        w.cond      = CondOutFree;
        w.target    = StepWait;
      end
      default:   begin
        w.cond   = CondFire;
        w.stay   = 1'b0;
        w.target = StepWait;
      end
    endcase
    return w;
  endfunction

  assign uc = ucode_rom(pc_q);

  always_comb begin
    case (uc.cond)
      CondFire:    cond_hit = status_i.fire;
      CondDivDone: cond_hit = status_i.div_done;
      CondRunBad:  cond_hit = status_i.run_bad;
      CondLast:    cond_hit = status_i.last;
      CondOutFree: cond_hit = status_i.out_free;
      default:     cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    if (pc_q > StepPut) begin
      pc_d = StepWait;
    end else if (cond_hit) begin
      pc_d = uc.target;
    end else if (uc.stay) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = uc.ctrl;

`ifndef SYNTHESIS
  a_fire_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == StepWait && status_i.fire) |=> pc_q == StepDiv)
    else $error("accepted request did not start the division");
  a_last_to_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == StepShift && status_i.last) |=> pc_q == StepPut)
    else $error("last bit did not lead to the result step");
`endif

endmodule

>>> rtl/rf46r_datapath.sv
// run quantizer, shift register, frame parser and held joystick values
module rf46r_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rf46r_pkg::ctrl_t            ctrl_i,
  input  rf46r_pkg::in_item_t         item_i,
  input  logic [rf46r_pkg::PeriodW-1:0] period_i,
  input  logic [rf46r_pkg::TagW-1:0]    tag_i,
  output logic                        div_done_o,
  output logic                        run_bad_o,
  output logic                        last_o,
  output logic                        fresh_o,
  output logic [rf46r_pkg::PosW-1:0]  held_x_o,
  output logic [rf46r_pkg::PosW-1:0]  held_y_o,
  output logic [rf46r_pkg::BtnW-1:0]  held_btn_o
);
  import rf46r_pkg::*;

  logic [NumW-1:0]  num_q, num_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             level_q, level_d;
  logic             fresh_q, fresh_d;

  logic [11:0]      sh_q, sh_d;
  logic             frame_q, frame_d;
  logic [3:0]       bitc_q, bitc_d;
  logic [3:0]       idx_q, idx_d;
  logic [3:0]       flen_q, flen_d;
  logic [7:0]       b1_q, b1_d, b2_q, b2_d, b3_q, b3_d, b4_q, b4_d;
  logic [PosW-1:0]  hx_q, hx_d, hy_q, hy_d;
  logic [BtnW-1:0]  hb_q, hb_d;

  logic [11:0]      sh_nx;
  logic [3:0]       bitc_nx;
  logic [4:0]       hi, lo;
  logic [7:0]       val;
  logic [4:0]       idx_nx;
  logic [3:0]       flen_eff;
  logic [7:0]       b1_e, b2_e, b3_e, b4_e;

  // quantizer: count whole periods in the rounded length, saturating at RunMax
  assign div_done_o = (num_q < NumW'(period_i)) || (cnt_q == RunMax);
  assign run_bad_o  = (cnt_q == 4'd0) || (cnt_q == RunMax);
  assign last_o     = (cnt_q == 4'd1);

  assign sh_nx   = {level_q, sh_q[11:1]};
  assign bitc_nx = bitc_q + 4'd1;
  assign hi      = sym_decode(sh_nx[5:0]);
  assign lo      = sym_decode(sh_nx[11:6]);
  assign val     = {hi[3:0], lo[3:0]};
  assign idx_nx  = {1'b0, idx_q} + 5'd1;
  assign flen_eff = (idx_q == 4'd0) ? val[3:0] : flen_q;
  assign b1_e    = (idx_q == 4'd1) ? val : b1_q;
  assign b2_e    = (idx_q == 4'd2) ? val : b2_q;
  assign b3_e    = (idx_q == 4'd3) ? val : b3_q;
  assign b4_e    = (idx_q == 4'd4) ? val : b4_q;

  always_comb begin
    num_d   = num_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    fresh_d = fresh_q;
    sh_d    = sh_q;
    frame_d = frame_q;
    bitc_d  = bitc_q;
    idx_d   = idx_q;
    flen_d  = flen_q;
    b1_d    = b1_q;
    b2_d    = b2_q;
    b3_d    = b3_q;
    b4_d    = b4_q;
    hx_d    = hx_q;
    hy_d    = hy_q;
    hb_d    = hb_q;

    if (ctrl_i.load) begin
      num_d   = NumW'(item_i.run_length_us) + NumW'(period_i[PeriodW-1:1]);
      cnt_d   = 4'd0;
      level_d = item_i.run_level;
      fresh_d = 1'b0;
    end

    if (ctrl_i.div && !div_done_o) begin
      num_d = num_q - NumW'(period_i);
      cnt_d = cnt_q + 4'd1;
    end

    if (ctrl_i.shift) begin
      cnt_d = cnt_q - 4'd1;
      sh_d  = sh_nx;
      if (!frame_q) begin
        if (sh_nx == SyncWord) begin
          frame_d = 1'b1;
          bitc_d  = 4'd0;
          idx_d   = 4'd0;
          flen_d  = 4'd0;
        end
      end else if (bitc_nx != BitsPerByte) begin
        bitc_d = bitc_nx;
      end else if (hi[4] || lo[4]) begin
        bitc_d  = bitc_nx;
        frame_d = 1'b0;
      end else if (idx_q == 4'd0 && (val < LenMin || val > LenMax)) begin
        bitc_d  = bitc_nx;
        flen_d  = val[3:0];
        frame_d = 1'b0;
      end else begin
        if (idx_q == 4'd0) begin
          flen_d = val[3:0];
        end
        b1_d   = b1_e;
        b2_d   = b2_e;
        b3_d   = b3_e;
        b4_d   = b4_e;
        idx_d  = idx_nx[3:0];
        bitc_d = 4'd0;
        // frame complete
        if (idx_nx >= {1'b0, flen_eff} && flen_eff != 4'd0) begin
          frame_d = 1'b0;
          if (idx_nx >= MinGoodLen && b1_e == tag_i) begin
            hx_d    = {b2_e, 2'b00};
            hy_d    = {b3_e, 2'b00};
            hb_d    = b4_e[BtnW-1:0];
            fresh_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 4'd0;
      fresh_q <= 1'b0;
      sh_q    <= '0;
      frame_q <= 1'b0;
      bitc_q  <= 4'd0;
      idx_q   <= 4'd0;
      flen_q  <= 4'd0;
      hx_q    <= HeldXReset;
      hy_q    <= HeldYReset;
      hb_q    <= '0;
    end else begin
      cnt_q   <= cnt_d;
      fresh_q <= fresh_d;
      sh_q    <= sh_d;
      frame_q <= frame_d;
      bitc_q  <= bitc_d;
      idx_q   <= idx_d;
      flen_q  <= flen_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      hb_q    <= hb_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    level_q <= level_d;
    b1_q    <= b1_d;
    b2_q    <= b2_d;
    b3_q    <= b3_d;
    b4_q    <= b4_d;
  end

  assign fresh_o    = fresh_q;
  assign held_x_o   = hx_q;
  assign held_y_o   = hy_q;
  assign held_btn_o = hb_q;

`ifndef SYNTHESIS
  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.shift |-> (cnt_q != 4'd0 && cnt_q != RunMax))
    else $error("bit shifted for a run outside one to fourteen bits");
  a_div_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.div && !div_done_o) |=> cnt_q == $past(cnt_q) + 4'd1)
    else $error("quotient did not advance on a subtract step");
`endif

endmodule

>>> tb/rf_4b6b_frame_receiver_unit_checker.sv
// channel monitor, behavioral predictor and result comparator of the 4b6b frame receiver
`timescale 1ns / 100ps

module rf_4b6b_frame_receiver_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  rf46r_pkg::in_item_t           in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  rf46r_pkg::out_item_t          out_item_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rf46r_pkg::PeriodW-1:0] cfg_wdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_o,
  output int                            fresh_o
);
  import rf46r_pkg::*;

  localparam int MsgBytes = 16;
  localparam logic [5:0] SymCode [16] = '{
    6'h0d, 6'h0e, 6'h13, 6'h15, 6'h16, 6'h19, 6'h1a, 6'h1c,
    6'h23, 6'h25, 6'h26, 6'h29, 6'h2a, 6'h2c, 6'h32, 6'h34
  };

  // receiver state
  logic [PeriodW-1:0] period_q;
  logic [TagW-1:0]    tag_q;
  logic [11:0]        shift_q;
  logic               synced;
  logic [3:0]         bit_cnt;
  logic [4:0]         byte_idx;
  logic [7:0]         frame_len;
  logic [7:0]         msg [MsgBytes];
  logic [PosW-1:0]    held_x;
  logic [PosW-1:0]    held_y;
  logic [BtnW-1:0]    held_btn;

  out_item_t joystick_q [$];
  int        fails;
  int        results;
  int        fresh_cnt;

  // {invalid, nibble}
  function automatic logic [4:0] symbol_of(logic [5:0] code);
    for (int k = 0; k < 16; k++) begin
      if (SymCode[k] == code) return {1'b0, 4'(k)};
    end
    return 5'h10;
  endfunction

  // one line bit into the deframer, high when a tagged frame completes
  function automatic logic push_bit(logic b);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] val;
    shift_q = {b, shift_q[11:1]};
    if (!synced) begin
      if (shift_q == SyncWord) begin
        synced    = 1'b1;
        bit_cnt   = '0;
        byte_idx  = '0;
        frame_len = '0;
      end
      return 1'b0;
    end
    bit_cnt = bit_cnt + 4'd1;
    if (bit_cnt != BitsPerByte) return 1'b0;
    hi = symbol_of(shift_q[5:0]);
    lo = symbol_of(shift_q[11:6]);
    if (hi[4] || lo[4]) begin
      synced = 1'b0;
      return 1'b0;
    end
    val = {hi[3:0], lo[3:0]};
    if (byte_idx == '0) begin
      frame_len = val;
      if (val < LenMin || val > LenMax) begin
        synced = 1'b0;
        return 1'b0;
      end
    end
    if (byte_idx < MsgBytes) begin
      msg[byte_idx] = val;
      byte_idx      = byte_idx + 5'd1;
    end
    bit_cnt = '0;
    if (8'(byte_idx) >= frame_len && frame_len != '0) begin
      synced = 1'b0;
      if (byte_idx >= MinGoodLen && msg[1] == tag_q) begin
        held_x   = {msg[2], 2'b00};
        held_y   = {msg[3], 2'b00};
        held_btn = msg[4][2:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_run(in_item_t req);
    int unsigned nbits;
    logic        fresh;
    out_item_t   res;
    fresh = 1'b0;
    if (period_q != '0) begin
      nbits = (32'(req.run_length_us) + 32'(period_q >> 1)) / 32'(period_q);
      if (nbits > 0 && nbits < 15) begin
        for (int i = 0; i < nbits; i++) begin
          if (push_bit(req.run_level)) fresh = 1'b1;
        end
      end
    end
    res.new_data   = fresh;
    res.x_position = held_x;
    res.y_position = held_y;
    res.buttons    = held_btn;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      period_q  = PeriodReset;
      tag_q     = TagReset;
      shift_q   = '0;
      synced    = 1'b0;
      bit_cnt   = '0;
      byte_idx  = '0;
      frame_len = '0;
      for (int i = 0; i < MsgBytes; i++) msg[i] = '0;
      held_x    = HeldXReset;
      held_y    = HeldYReset;
      held_btn  = '0;
      joystick_q.delete();
      fails     = 0;
      results   = 0;
      fresh_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgPeriod) period_q = cfg_wdata_i;
        else tag_q = cfg_wdata_i[TagW-1:0];
      end
      // results first: nothing taken at this edge can already be answered
      if (out_valid_i && out_ready_i) begin
        results++;
        if (out_item_i.new_data) fresh_cnt++;
        if (joystick_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%t result with no request waiting: %p", $realtime, out_item_i);
        end else begin
          want = joystick_q.pop_front();
          if (out_item_i !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%t mismatch: expected new=%0b x=%0d y=%0d btn=%0d, got new=%0b x=%0d y=%0d btn=%0d",
                       $realtime, want.new_data, want.x_position, want.y_position, want.buttons,
                       out_item_i.new_data, out_item_i.x_position, out_item_i.y_position,
                       out_item_i.buttons);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) joystick_q.push_back(predict_run(in_item_i));
    end
    fail_count_o <= fails;
    pending_o    <= joystick_q.size();
    results_o    <= results;
    fresh_o      <= fresh_cnt;
  end

endmodule

>>> tb/rf_4b6b_frame_receiver_unit_tb.sv
// stimulus, handshake pacing and verdict for the 4b6b frame receiver
`timescale 1ns / 100ps

module rf_4b6b_frame_receiver_unit_tb;
  import rf46r_pkg::*;

  localparam int QuietLimit = 3000;  // cycles without any handshake before giving up
  localparam int DrainWait  = 48;    // extra wait once no result is outstanding
  localparam int NumPhases  = 6;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic               cfg_we;
  logic               cfg_idx;
  logic [PeriodW-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int results;
  int fresh;

  logic [5:0] sym_code [16];  // nibble to 6-bit line code
  int         cur_period;
  int         cur_tag;
  bit         calm;           // last phase: no pacing gaps on either side
  bit         gappy;          // sender pacing for the current burst
  int         shifting_runs;  // requests that actually move bits
  int         total_runs;
  int         frames_sent;
  int         quiet_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  rf_4b6b_frame_receiver_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  rf_4b6b_frame_receiver_unit_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .fresh_o      (fresh)
  );

  // watchdog: any request or result taken counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("[rf_4b6b_frame_receiver_unit] ERROR");
      $finish;
    end
  end

  // result side: stretches of random back-pressure alternate with stretches of none
  initial begin
    int  stretch;
    bit  noisy;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stretch = $urandom_range(64, 256);
      noisy   = !calm && ($urandom_range(0, 2) != 0);
      repeat (stretch) begin
        @(posedge clk);
        if (noisy && !calm && $urandom_range(0, 5) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // offset inside the window that still rounds to the intended bit count
  function automatic int jitter();
    return int'($urandom_range(0, cur_period - 1)) - cur_period / 2;
  endfunction

  // one run request; valid stays up from one request to the next unless a gap is drawn
  task automatic send_run(input logic lvl, input int len);
    int nb;
    if (len < 0) len = 0;
    else if (len > 65535) len = 65535;
    if (!calm && gappy && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_item.run_level     <= lvl;
    in_item.run_length_us <= 16'(len);
    do @(posedge clk); while (!in_ready);
    total_runs++;
    if (cur_period != 0) begin
      nb = (len + cur_period / 2) / cur_period;
      if (nb >= 1 && nb <= 14) shifting_runs++;
    end
  endtask

  // quiet the request side and wait out everything in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // both registers written back to back, period then tag; the tag gets junk above bit 7
  task automatic set_config(input int period, input int tag);
    cur_period = period;
    cur_tag    = tag;
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgPeriod;
    cfg_wdata <= PeriodW'(period);
    @(posedge clk);
    cfg_idx   <= CfgTag;
    cfg_wdata <= {4'($urandom_range(0, 15)), 8'(tag)};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // preamble, sync word, encoded bytes and a short tail, sent as level runs
  task automatic send_frame();
    bit         line[$];
    int         flen;
    int         nbytes;
    int         k;
    int         run;
    int         pos;
    logic [7:0] data;
    logic [5:0] code;
    gappy = !calm && ($urandom_range(0, 2) != 0);
    frames_sent++;
    case ($urandom_range(0, 19))
      0:       flen = $urandom_range(0, 3);     // length byte too small
      1:       flen = $urandom_range(16, 255);  // length byte too large
      2:       flen = 4;                        // too short to carry a payload
      3:       flen = 15;
      4:       flen = $urandom_range(11, 14);
      default: flen = $urandom_range(5, 10);
    endcase
    nbytes = (flen >= 4 && flen <= 15) ? flen : 3;
    pos = $urandom_range(0, 1);
    repeat ($urandom_range(4, 24)) begin
      line.push_back(pos[0]);
      pos = pos ^ 1;
    end
    for (int i = 0; i < 12; i++) line.push_back(SyncWord[i]);
    pos = line.size();
    for (int b = 0; b < nbytes; b++) begin
      if (b == 0) data = 8'(flen);
      else if (b == 1) data = ($urandom_range(0, 4) != 0) ? 8'(cur_tag) : 8'($urandom_range(0, 255));
      else data = 8'($urandom_range(0, 255));
      code = sym_code[data[7:4]];
      for (int i = 0; i < 6; i++) line.push_back(code[i]);
      code = sym_code[data[3:0]];
      for (int i = 0; i < 6; i++) line.push_back(code[i]);
    end
    // occasional line error inside the coded part
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(pos, line.size() - 1);
      line[k] = !line[k];
    end
    repeat ($urandom_range(0, 6)) line.push_back(1'($urandom_range(0, 1)));
    k = 0;
    while (k < line.size()) begin
      run = 1;
      while (k + run < line.size() && line[k + run] == line[k] && run < 14) run++;
      send_run(line[k], run * cur_period + jitter());
      k += run;
    end
  endtask

  // stray runs, many right on a rounding boundary
  task automatic send_noise();
    int len;
    int n;
    int p;
    p     = cur_period;
    gappy = !calm && ($urandom_range(0, 2) != 0);
    repeat ($urandom_range(1, 4)) begin
      n = $urandom_range(0, 16);
      case ($urandom_range(0, 4))
        0:       len = $urandom_range(0, 65535);
        1:       len = n * p - p / 2;
        2:       len = n * p + (p - 1 - p / 2);
        3:       len = n * p + (p - p / 2);
        default: len = n * p + jitter();
      endcase
      send_run(1'($urandom_range(0, 1)), len);
    end
  endtask

  initial begin
    logic [4:0] dec;
    int         quota;
    in_valid   <= 1'b0;
    in_item    <= '0;
    out_ready  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CfgPeriod;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    calm          = 1'b0;
    gappy         = 1'b0;
    shifting_runs = 0;
    total_runs    = 0;
    frames_sent   = 0;
    cur_period    = 500;
    cur_tag       = 126;
    // invert the symbol decoder into an encoder for stimulus
    for (int c = 0; c < 64; c++) begin
      dec = sym_decode(6'(c));
      if (!dec[4]) sym_code[dec[3:0]] = 6'(c);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: run lengths at the edges of zero, one, fourteen and fifteen bits
    send_run(1'b0, 0);
    send_run(1'b1, 65535);
    send_run(1'b1, 249);
    send_run(1'b0, 250);
    send_run(1'b1, 749);
    send_run(1'b0, 750);
    send_run(1'b1, 6749);
    send_run(1'b0, 7249);
    send_run(1'b1, 7250);
    send_run(1'b0, 1);
    send_run(1'b1, 32768);
    // zero period: every run is dropped
    settle();
    set_config(0, 126);
    send_run(1'b1, 65535);
    send_run(1'b0, 500);
    send_run(1'b1, 0);
    // a long period of 4000
    settle();
    set_config(4000, 255);
    send_run(1'b1, 65535);
    send_run(1'b0, 57999);
    send_run(1'b1, 1999);
    send_run(1'b0, 2000);

    // random phases: mostly framed traffic, some stray runs; a phase overshoots its quota
    // by part of a frame, so the quotas sit below the intended request count
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0:       begin set_config(500, 126);                                  quota = 280; end
        1:       begin set_config(2, 0);                                      quota = 200; end
        2:       begin set_config(4000, 255);                                 quota = 200; end
        3:       begin set_config($urandom_range(2, 4000), $urandom_range(0, 255)); quota = 200; end
        4:       begin set_config($urandom_range(2, 40), $urandom_range(0, 255));   quota = 200; end
        default: begin set_config($urandom_range(100, 1000), 126);            quota = 240; end
      endcase
      calm = (ph == NumPhases - 1);
      shifting_runs = 0;
      while (shifting_runs < quota) begin
        if ($urandom_range(0, 3) != 0) send_frame();
        else send_noise();
      end
    end

    settle();
    $display("run summary: %0d run requests (%0d framed bursts) over %0d register settings",
             total_runs, frames_sent, NumPhases + 3);
    $display("run summary: %0d results checked, %0d flagged a fresh joystick update",
             results, fresh);
    if (fail_count == 0) begin
      $display("[rf_4b6b_frame_receiver_unit] OK");
    end else begin
      $display("[rf_4b6b_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rf46r_pkg.sv
rtl/rf46r_sequencer.sv
rtl/rf46r_datapath.sv
rtl/rf_4b6b_frame_receiver_unit.sv
tb/rf_4b6b_frame_receiver_unit_checker.sv
tb/rf_4b6b_frame_receiver_unit_tb.sv
